/* hdl/mma_pkg.sv */
// Package for the modulation matrix accumulator.
// Command codes, status codes, fixed-point constants and the queue beat type.
// No dependencies.
package mma_pkg;

    typedef enum logic [2:0] {
        CMD_SET_ENTRY    = 3'd0,
        CMD_REMOVE_ENTRY = 3'd1,
        CMD_CLEAR_ALL    = 3'd2,
        CMD_SET_SOURCE   = 3'd3,
        CMD_APPLY        = 3'd4
    } cmd_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    localparam logic signed [16:0] ONE_Q14     = 17'sd16384;
    localparam logic signed [27:0] TOTAL_LIMIT = 28'sd1048576;

    // Operation handed from the front part to the back part
    typedef enum logic [5:0] {
        OP_NONE   = 6'b000001,  // answer with a fixed status, zero fields or the passed-through base value
        OP_SET    = 6'b000010,
        OP_REMOVE = 6'b000100,
        OP_CLEAR  = 6'b001000,
        OP_APPLY  = 6'b010000,
        OP_SOURCE = 6'b100000   // write one source value
    } op_t;

    // One queued beat: classified command with its operands
    typedef struct packed {
        op_t                op;
        logic [1:0]         status;
        logic [7:0]         param_id;
        logic [5:0]         source_addr;
        logic signed [15:0] depth;
        logic               bipolar;
        logic signed [15:0] source_value;
        logic signed [15:0] base_value;
        logic               pass_base;   // apply while not prepared
    } work_t;

endpackage

/* hdl/mma_front.sv */
// Front part: classifies accepted input beats into queue beats, applying the
// prepared checks, the source range check and the depth clamp. Depends on mma_pkg.
module mma_front
    import mma_pkg::*;
#(
    parameter int SOURCE_KINDS   = 8,
    parameter int SOURCE_INDEXES = 8
)
(
    input  logic               prepared,
    input  logic               in_valid,
    input  logic [2:0]         cmd,
    input  logic [7:0]         param_id,
    input  logic [2:0]         source_kind,
    input  logic [2:0]         source_index,
    input  logic signed [15:0] depth,
    input  logic               bipolar,
    input  logic signed [15:0] source_value,
    input  logic signed [15:0] base_value,
    output logic               q_valid,
    output work_t              q_data
);

    logic source_ok;
    logic signed [15:0] depth_clamped;

    assign source_ok = ({29'd0, source_kind} < SOURCE_KINDS)
                    && ({29'd0, source_index} < SOURCE_INDEXES);

    // Depth clamp to plus or minus 1.0
    always_comb
    begin
        if (depth > 16'sd16384)
            depth_clamped = 16'sd16384;
        else if (depth < -16'sd16384)
            depth_clamped = -16'sd16384;
        else
            depth_clamped = depth;
    end

    assign q_valid = in_valid;

    // Classification
    always_comb
    begin
        q_data              = '0;
        q_data.op           = OP_NONE;
        q_data.status       = STATUS_OK;
        q_data.param_id     = param_id;
        q_data.source_addr  = {source_kind, source_index};
        q_data.depth        = depth_clamped;
        q_data.bipolar      = bipolar;
        q_data.source_value = source_value;
        q_data.base_value   = base_value;
        q_data.pass_base    = 1'b0;
        unique case (cmd)
            CMD_SET_ENTRY:
            begin
                if (!prepared)
                    q_data.status = STATUS_IGNORED;
                else
                    q_data.op = OP_SET;
            end
            CMD_REMOVE_ENTRY: q_data.op = OP_REMOVE;
            CMD_CLEAR_ALL:    q_data.op = OP_CLEAR;
            CMD_SET_SOURCE:
            begin
                if (!prepared)
                    q_data.status = STATUS_IGNORED;
                else if (source_ok)
                    q_data.op = OP_SOURCE;
            end
            CMD_APPLY:
            begin
                if (prepared)
                    q_data.op = OP_APPLY;
                else
                    q_data.pass_base = 1'b1;
            end
            default: q_data.op = OP_NONE;
        endcase
    end

endmodule

/* hdl/mma_queue.sv */
// Two-entry queue between the front and back parts.
// Depends on mma_pkg for the beat type.
module mma_queue
    import mma_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  work_t in_data,
    output logic  in_ready,
    output logic  out_valid,
    output work_t out_data,
    input  logic  out_take
);

    work_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_take && out_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |=> (count_reg <= 2'd1)) else $error("queue grew by two");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> (count_reg == 2'd2))
        else $error("full queue lost a beat");
`endif

endmodule

/* hdl/mma_back.sv */
// Back part: walks the entry table one slot per cycle for set, remove and
// apply, writes the source store, and produces the result beat.
// Depends on mma_pkg.
module mma_back
    import mma_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_PARAMS  = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  work_t              q_data,
    output logic               q_take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] result_value,
    output logic signed [21:0] total_mod,
    output logic               changed,
    output logic [1:0]         status
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(MAX_ENTRIES - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // Entry table: fields in a memory, valid bits in flops
    logic [8+6+1+16-1:0] ent_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic signed [15:0] src_mem [64];
    logic [63:0] src_wr_reg;

    state_t state_reg, state_next;
    work_t  cur_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] free_reg, free_next;
    logic free_found_reg, free_found_next;
    logic [IW-1:0] hit_reg, hit_next;
    logic hit_found_reg, hit_found_next;
    logic signed [27:0] sum_reg, sum_next;
    logic [30:0] ent_q_reg;
    logic [IW-1:0] addr_q_reg;
    logic ent_v_reg, rd_pend_reg;
    logic signed [15:0] src_q_reg;
    logic src_known_reg;
    logic bip_q_reg;
    logic signed [15:0] depth_q_reg;
    logic mac_v_reg;
    logic signed [32:0] prod_reg;
    logic prod_v_reg;
    logic out_valid_reg;
    logic signed [15:0] res_reg;
    logic signed [21:0] tot_reg;
    logic chg_reg;
    logic [1:0] st_reg;

    logic q_fire, done_fire;
    logic match_full, match_param;
    logic [7:0] e_param;
    logic [5:0] e_src;
    logic e_bip;
    logic signed [15:0] e_depth;
    logic signed [16:0] s_clamp;
    logic scan_end;
    logic param_ok;
    logic signed [27:0] sum_sat;
    logic signed [28:0] base_sum;
    logic signed [15:0] res_clamp;
    logic write_set, write_new;
    logic [IW-1:0] write_addr;

    assign q_take    = (state_reg == ST_IDLE);
    assign q_fire    = q_valid && q_take;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign {e_param, e_src, e_bip, e_depth} = ent_q_reg;
    assign param_ok = ({24'd0, cur_reg.param_id} < MAX_PARAMS);
    assign match_param = ent_v_reg && (e_param == cur_reg.param_id);
    assign match_full  = match_param && (e_src == cur_reg.source_addr);
    assign scan_end = (idx_reg == LAST);
    assign write_set = (state_reg == ST_WRITE) && param_ok
                    && (hit_found_reg || free_found_reg);
    assign write_new = write_set && !hit_found_reg;
    assign write_addr = hit_found_reg ? hit_reg : free_reg;

    // Source clamp by polarity; unwritten sources read as zero
    always_comb
    begin
        s_clamp = src_known_reg ? 17'(src_q_reg) : 17'sd0;
        if (s_clamp > ONE_Q14)
            s_clamp = ONE_Q14;
        else if (bip_q_reg && s_clamp < -ONE_Q14)
            s_clamp = -ONE_Q14;
        else if (!bip_q_reg && s_clamp < 17'sd0)
            s_clamp = 17'sd0;
    end

    // Saturation and result
    always_comb
    begin
        if (sum_reg > TOTAL_LIMIT)
            sum_sat = TOTAL_LIMIT;
        else if (sum_reg < -TOTAL_LIMIT)
            sum_sat = -TOTAL_LIMIT;
        else
            sum_sat = sum_reg;
        base_sum = 29'(cur_reg.base_value) + 29'(sum_sat);
        if (base_sum < 29'sd0)
            res_clamp = 16'sd0;
        else if (base_sum > 29'sd16384)
            res_clamp = 16'sd16384;
        else
            res_clamp = base_sum[15:0];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        free_next = free_reg;
        free_found_next = free_found_reg;
        hit_next = hit_reg;
        hit_found_next = hit_found_reg;
        sum_next = sum_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_fire)
                begin
                    idx_next = '0;
                    free_found_next = 1'b0;
                    hit_found_next = 1'b0;
                    sum_next = '0;
                    if (q_data.op == OP_SET || q_data.op == OP_APPLY
                        || q_data.op == OP_REMOVE)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                // one slot read issued per cycle
                if (scan_end)
                    state_next = ST_MUL;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_MUL:
            begin
                // drain the read and multiply pipeline
                if (!rd_pend_reg && !mac_v_reg && !prod_v_reg)
                    state_next = (cur_reg.op == OP_SET) ? ST_WRITE : ST_DONE;
            end
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        // slot evaluated in the cycle after its read is issued
        if (rd_pend_reg)
        begin
            if (!ent_v_reg && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_next = addr_q_reg;
            end
            if (match_full && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_next = addr_q_reg;
            end
        end
        if (prod_v_reg)
            sum_next = sum_reg + 28'(prod_reg >>> 14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            src_wr_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            mac_v_reg <= 1'b0;
            prod_v_reg <= 1'b0;
            free_found_reg <= 1'b0;
            hit_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            free_found_reg <= free_found_next;
            hit_found_reg <= hit_found_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
            mac_v_reg <= rd_pend_reg && (cur_reg.op == OP_APPLY) && match_param;
            prod_v_reg <= mac_v_reg;
            if (q_fire && q_data.op == OP_SOURCE)
                src_wr_reg[q_data.source_addr] <= 1'b1;
            if (q_fire && q_data.op == OP_CLEAR)
                valid_reg <= '0;
            else if (rd_pend_reg && cur_reg.op == OP_REMOVE && match_full)
                valid_reg[addr_q_reg] <= 1'b0;
            else if (write_new)
                valid_reg[free_reg] <= 1'b1;
            if (done_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers and memories
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        free_reg <= free_next;
        hit_reg <= hit_next;
        sum_reg <= sum_next;
        if (q_fire)
            cur_reg <= q_data;
        ent_q_reg <= ent_mem[idx_reg];
        ent_v_reg <= valid_reg[idx_reg];
        addr_q_reg <= idx_reg;
        src_q_reg <= src_mem[e_src];
        src_known_reg <= src_wr_reg[e_src];
        bip_q_reg <= e_bip;
        depth_q_reg <= e_depth;
        prod_reg <= 33'(s_clamp) * 33'(depth_q_reg);
        if (q_fire && q_data.op == OP_SOURCE)
            src_mem[q_data.source_addr] <= q_data.source_value;
        if (write_set)
            ent_mem[write_addr] <= {cur_reg.param_id, cur_reg.source_addr,
                                    cur_reg.bipolar, cur_reg.depth};
        if (done_fire)
        begin
            if (cur_reg.op == OP_APPLY)
            begin
                res_reg <= res_clamp;
                tot_reg <= sum_sat[21:0];
                chg_reg <= (sum_sat != 28'sd0);
                st_reg  <= STATUS_OK;
            end
            else
            begin
                res_reg <= cur_reg.pass_base ? cur_reg.base_value : 16'sd0;
                tot_reg <= '0;
                chg_reg <= 1'b0;
                if (cur_reg.op == OP_SET)
                    st_reg <= (!param_ok || hit_found_reg || free_found_reg)
                            ? STATUS_OK : STATUS_FULL;
                else
                    st_reg <= cur_reg.status;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign total_mod    = tot_reg;
    assign changed      = chg_reg;
    assign status       = st_reg;

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> (state_reg == ST_IDLE)) else $error("take outside idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg) else $error("result dropped");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
`endif

endmodule

/* hdl/modulation_matrix_accumulator.sv */
// Top level of the modulation matrix accumulator.
// Instantiates mma_front, mma_queue and mma_back; depends on mma_pkg.
//
//  channel  signals                         direction
//  in       in_valid / in_stall + fields    item in
//  out      out_valid / out_stall + fields  result out
//  cfg      cfg_we / cfg_wdata              prepared register
//
// remove_entry, set_entry and apply walk the entry table in the back part one slot per cycle,
// feeding a three-stage read and multiply pipeline; set_entry then writes its slot in a
// write state. Other commands go straight to the done state.
// The result register loads in the done state; the back waits there on out_stall.
// Reset clears entry valid bits and source written bits at once; no sweep.
// A two-beat queue lets the front accept while the back walks or waits on out_stall.
module modulation_matrix_accumulator
    import mma_pkg::*;
#(
    parameter int MAX_ENTRIES    = 64,
    parameter int MAX_PARAMS     = 256,
    parameter int SOURCE_KINDS   = 8,
    parameter int SOURCE_INDEXES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic [7:0]         param_id,
    input  logic [2:0]         source_kind,
    input  logic [2:0]         source_index,
    input  logic signed [15:0] depth,
    input  logic               bipolar,
    input  logic signed [15:0] source_value,
    input  logic signed [15:0] base_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] result_value,
    output logic signed [21:0] total_mod,
    output logic               changed,
    output logic [1:0]         status
);

    logic prepared_reg;
    logic q_in_ready, f_valid, q_valid, q_take;
    work_t f_data, q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prepared_reg <= 1'b0;
        else if (cfg_we)
            prepared_reg <= cfg_wdata;
    end

    assign in_stall = !q_in_ready;

    mma_front #(.SOURCE_KINDS(SOURCE_KINDS), .SOURCE_INDEXES(SOURCE_INDEXES)) u_front
    (
        .prepared(prepared_reg),
        .in_valid(in_valid && q_in_ready), .cmd(cmd), .param_id(param_id),
        .source_kind(source_kind), .source_index(source_index), .depth(depth),
        .bipolar(bipolar), .source_value(source_value), .base_value(base_value),
        .q_valid(f_valid), .q_data(f_data)
    );

    mma_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_data(f_data),
        .in_ready(q_in_ready), .out_valid(q_valid), .out_data(q_data),
        .out_take(q_take)
    );

    mma_back #(
        .MAX_ENTRIES(MAX_ENTRIES), .MAX_PARAMS(MAX_PARAMS)
    ) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_take(q_take),
        .out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
        .total_mod(total_mod), .changed(changed), .status(status)
    );

endmodule
